[src/matrix_multiply_macros.svh]
// ----------------------------------------------------------------------------
// matrix_multiply assertion macros
// shared property wrappers, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// same-edge implication
`define MM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-edge implication
`define MM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mm_pkg.sv]
// ----------------------------------------------------------------------------
// mm_pkg
// shared types, codes and constants of the matrix multiply block
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

  localparam int unsigned MAX_DIM_DEF    = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned IDX_IN_W  = 3;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned DIM_RESET = 8;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } mm_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_MISMATCH = 2'd2
  } mm_status_e;

  typedef enum logic [2:0] {
    OP_WRITE_A,
    OP_WRITE_B,
    OP_RANGE_ERR,
    OP_DIM_ERR,
    OP_COMPUTE
  } mm_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN,
    BK_EMIT
  } mm_bk_state_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } mm_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] a_rows;
    logic [CFG_W-1:0] a_cols;
    logic [CFG_W-1:0] b_rows;
    logic [CFG_W-1:0] b_cols;
  } mm_dims_t;

  typedef struct packed {
    mm_op_e              kind;
    logic [IDX_IN_W-1:0] row;
    logic [IDX_IN_W-1:0] col;
  } mm_op_t;

endpackage

`default_nettype wire

[src/mm_front.sv]
// ----------------------------------------------------------------------------
// mm_front
// accepts input transactions, checks indices and sizes, queues operations
// ----------------------------------------------------------------------------
`default_nettype none

module mm_front import mm_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic        [CMD_W-1:0]      cmd_i,
  input  wire logic        [IDX_IN_W-1:0]   row_index_i,
  input  wire logic        [IDX_IN_W-1:0]   col_index_i,
  input  wire logic signed [IN_W-1:0]       element_value_i,
  input  wire mm_dims_t                     dims_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output mm_op_t                            q_op_o,
  output logic             [DATA_WIDTH-1:0] q_value_o
);

  logic a_oob;
  logic b_oob;
  logic keep;

  assign in_ready_o = !q_full_i;

  assign a_oob = (CFG_W'(row_index_i) >= dims_i.a_rows) ||
                 (CFG_W'(col_index_i) >= dims_i.a_cols);
  assign b_oob = (CFG_W'(row_index_i) >= dims_i.b_rows) ||
                 (CFG_W'(col_index_i) >= dims_i.b_cols);

  // sign-extend or cut to the store width
  assign q_value_o = DATA_WIDTH'(element_value_i);

  always_comb begin
    keep          = 1'b1;
    q_op_o.row    = row_index_i;
    q_op_o.col    = col_index_i;
    q_op_o.kind   = OP_COMPUTE;
    case (mm_cmd_e'(cmd_i))
      CMD_WRITE_A: begin
        q_op_o.kind = a_oob ? OP_RANGE_ERR : OP_WRITE_A;
      end
      CMD_WRITE_B: begin
        q_op_o.kind = b_oob ? OP_RANGE_ERR : OP_WRITE_B;
      end
      CMD_COMPUTE: begin
        q_op_o.kind = (dims_i.a_cols != dims_i.b_rows) ? OP_DIM_ERR : OP_COMPUTE;
      end
      default: begin
        // unused command is dropped
        keep = 1'b0;
      end
    endcase
    q_push_o = in_valid_i && in_ready_o && keep;
  end

endmodule

`default_nettype wire

[src/mm_fifo.sv]
// ----------------------------------------------------------------------------
// mm_fifo
// short operation queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module mm_fifo import mm_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[src/mm_back.sv]
// ----------------------------------------------------------------------------
// mm_back
// element stores, multiply-accumulate sequencer and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mm_back import mm_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mm_dims_t                     dims_i,
  input  wire logic                         q_valid_i,
  input  wire mm_op_t                       q_op_i,
  input  wire logic        [DATA_WIDTH-1:0] q_value_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic             [IDX_IN_W-1:0]   out_row_o,
  output logic             [IDX_IN_W-1:0]   out_col_o,
  output logic signed      [OUT_W-1:0]      product_value_o,
  output logic             [STATUS_W-1:0]   status_o,
  output logic                              last_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned HALF_W = 32;

  mm_bk_state_e state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  mm_op_t op_q;

  logic [DATA_WIDTH-1:0] mem_a_q [DEPTH];
  logic [DATA_WIDTH-1:0] mem_b_q [DEPTH];
  logic [DATA_WIDTH-1:0] a_rd_q, b_rd_q;
  logic                  rd_vld_q, rd_last_q;
  logic                  mul_vld_q, mul_last_q;
  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;

  logic                wr_a, wr_b, issue, issue_last;
  logic                k_last, elem_last;
  logic [ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;

  logic                res_vld_q, res_vld_d;
  logic [IDX_IN_W-1:0] res_row_q, res_row_d, res_col_q, res_col_d;
  logic [OUT_W-1:0]    res_val_q, res_val_d;
  mm_status_e          res_st_q, res_st_d;
  logic                res_last_q, res_last_d;

  assign wr_addr   = ADDR_W'(MAX_DIM * q_op_i.row + q_op_i.col);
  assign rd_addr_a = ADDR_W'(MAX_DIM * i_q + k_q);
  assign rd_addr_b = ADDR_W'(MAX_DIM * k_q + j_q);

  assign k_last    = (CFG_W'(k_q) + CFG_W'(1)) == dims_i.a_cols;
  assign elem_last = ((CFG_W'(i_q) + CFG_W'(1)) == dims_i.a_rows) &&
                     ((CFG_W'(j_q) + CFG_W'(1)) == dims_i.b_cols);

  // product modulo the store width, one register stage
  if (DATA_WIDTH <= HALF_W) begin : g_mul_narrow
    logic [DATA_WIDTH-1:0] mul_q;
    always_ff @(posedge clk_i) begin
      if (rd_vld_q) begin
        mul_q <= a_rd_q * b_rd_q;
      end
    end
    assign prod = mul_q;
  end else begin : g_mul_wide
    localparam int unsigned HI_W = DATA_WIDTH - HALF_W;
    logic [2*HALF_W-1:0] lo_q;
    logic [HI_W-1:0]     x1_q, x2_q;
    always_ff @(posedge clk_i) begin
      if (rd_vld_q) begin
        lo_q <= a_rd_q[HALF_W-1:0] * b_rd_q[HALF_W-1:0];
        x1_q <= a_rd_q[DATA_WIDTH-1:HALF_W] * b_rd_q[HI_W-1:0];
        x2_q <= a_rd_q[HI_W-1:0] * b_rd_q[DATA_WIDTH-1:HALF_W];
      end
    end
    assign prod = DATA_WIDTH'(lo_q) + {x1_q + x2_q, {HALF_W{1'b0}}};
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    q_pop_o    = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    issue      = 1'b0;
    issue_last = 1'b0;
    acc_d      = mul_vld_q ? acc_q + prod : acc_q;
    res_vld_d  = out_ready_i ? 1'b0 : res_vld_q;
    res_row_d  = res_row_q;
    res_col_d  = res_col_q;
    res_val_d  = res_val_q;
    res_st_d   = res_st_q;
    res_last_d = res_last_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_op_i.kind)
            OP_WRITE_A: wr_a = 1'b1;
            OP_WRITE_B: wr_b = 1'b1;
            OP_RANGE_ERR, OP_DIM_ERR: state_d = BK_EMIT;
            OP_COMPUTE: begin
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              acc_d   = '0;
              state_d = BK_MAC;
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end
      BK_MAC: begin
        issue      = 1'b1;
        issue_last = k_last;
        if (k_last) begin
          k_d     = '0;
          state_d = BK_DRAIN;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      BK_DRAIN: begin
        if (mul_vld_q && mul_last_q) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!res_vld_q || out_ready_i) begin
          res_vld_d = 1'b1;
          case (op_q.kind)
            OP_RANGE_ERR: begin
              res_row_d  = op_q.row;
              res_col_d  = op_q.col;
              res_val_d  = '0;
              res_st_d   = ST_RANGE;
              res_last_d = 1'b1;
            end
            OP_DIM_ERR: begin
              res_row_d  = '0;
              res_col_d  = '0;
              res_val_d  = '0;
              res_st_d   = ST_MISMATCH;
              res_last_d = 1'b1;
            end
            default: begin
              res_row_d  = IDX_IN_W'(i_q);
              res_col_d  = IDX_IN_W'(j_q);
              res_val_d  = OUT_W'(signed'(acc_q));
              res_st_d   = ST_OK;
              res_last_d = elem_last;
            end
          endcase
          if (op_q.kind == OP_COMPUTE && !elem_last) begin
            // next element in row-major order
            if ((CFG_W'(j_q) + CFG_W'(1)) == dims_i.b_cols) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
            acc_d   = '0;
            state_d = BK_MAC;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      mul_vld_q  <= 1'b0;
      mul_last_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      rd_vld_q   <= issue;
      rd_last_q  <= issue_last;
      mul_vld_q  <= rd_vld_q;
      mul_last_q <= rd_last_q;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q <= q_op_i;
    end
    acc_q      <= acc_d;
    res_row_q  <= res_row_d;
    res_col_q  <= res_col_d;
    res_val_q  <= res_val_d;
    res_st_q   <= res_st_d;
    res_last_q <= res_last_d;
  end

  // element stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a_q[wr_addr] <= q_value_i;
    end
    if (issue) begin
      a_rd_q <= mem_a_q[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b_q[wr_addr] <= q_value_i;
    end
    if (issue) begin
      b_rd_q <= mem_b_q[rd_addr_b];
    end
  end

  assign out_valid_o     = res_vld_q;
  assign out_row_o       = res_row_q;
  assign out_col_o       = res_col_q;
  assign product_value_o = res_val_q;
  assign status_o        = res_st_q;
  assign last_o          = res_last_q;

endmodule

`default_nettype wire

[src/matrix_multiply.sv]
// loads: an accepted load waits in the queue and is written to its store once the back is idle
// a bad index or a size mismatch gives a single result, via the queue, the emit state and the result register
// compute: each element of C is read, multiplied, accumulated and emitted in turn,
// in row-major order, by the single mac unit
// throughput: one input transaction per cycle while the two-entry queue has room
// reset: control and queue cleared, size registers at the full size, stores left unset
`default_nettype none

`include "matrix_multiply_macros.svh"

// ----------------------------------------------------------------------------
// matrix_multiply
// integer matrix product over two on-chip element stores, with apb size registers
// ----------------------------------------------------------------------------
module matrix_multiply import mm_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic        [PADDR_W-1:0]  paddr,
  input  wire logic        [PDATA_W-1:0]  pwdata,
  output logic             [PDATA_W-1:0]  prdata,
  output logic                            pready,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic        [CMD_W-1:0]    cmd_i,
  input  wire logic        [IDX_IN_W-1:0] row_index_i,
  input  wire logic        [IDX_IN_W-1:0] col_index_i,
  input  wire logic signed [IN_W-1:0]     element_value_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [IDX_IN_W-1:0] out_row_o,
  output logic             [IDX_IN_W-1:0] out_col_o,
  output logic signed      [OUT_W-1:0]    product_value_o,
  output logic             [STATUS_W-1:0] status_o,
  output logic                            last_o
);

  localparam int unsigned Q_W = $bits(mm_op_t) + DATA_WIDTH;

  mm_dims_t cfg_q, cfg_d;
  logic     cfg_wr;
  mm_reg_e  cfg_sel;

  logic                  q_push, q_full, q_pop, q_valid;
  mm_op_t                push_op, head_op;
  logic [DATA_WIDTH-1:0] push_val, head_val;

  // sizes saturate on write: zero reads as one, anything past the store as the store size
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = CFG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign cfg_sel = mm_reg_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_A_ROWS: cfg_d.a_rows = clamp_dim(pwdata[CFG_W-1:0]);
        REG_A_COLS: cfg_d.a_cols = clamp_dim(pwdata[CFG_W-1:0]);
        REG_B_ROWS: cfg_d.b_rows = clamp_dim(pwdata[CFG_W-1:0]);
        REG_B_COLS: cfg_d.b_cols = clamp_dim(pwdata[CFG_W-1:0]);
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows <= clamp_dim(CFG_W'(DIM_RESET));
      cfg_q.a_cols <= clamp_dim(CFG_W'(DIM_RESET));
      cfg_q.b_rows <= clamp_dim(CFG_W'(DIM_RESET));
      cfg_q.b_cols <= clamp_dim(CFG_W'(DIM_RESET));
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read back the saturated value
  always_comb begin
    case (cfg_sel)
      REG_A_ROWS: prdata = PDATA_W'(cfg_q.a_rows);
      REG_A_COLS: prdata = PDATA_W'(cfg_q.a_cols);
      REG_B_ROWS: prdata = PDATA_W'(cfg_q.b_rows);
      REG_B_COLS: prdata = PDATA_W'(cfg_q.b_cols);
      default:    prdata = '0;
    endcase
  end

  // ---------------- front: accept and classify ----------------
  mm_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .dims_i          (cfg_q),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_op_o          (push_op),
    .q_value_o       (push_val)
  );

  // ---------------- queue: lets either side stall alone ----------------
  mm_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_op, push_val}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      ({head_op, head_val})
  );

  // ---------------- back: stores, mac walk, result register ----------------
  mm_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dims_i          (cfg_q),
    .q_valid_i       (q_valid),
    .q_op_i          (head_op),
    .q_value_i       (head_val),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  // ---------------- assertions ----------------
  // every error result closes its run
  `MM_ASSERT_IMP(a_err_last, out_valid_o && (status_o != ST_OK), last_o, "error result without last")

  // a product element lies inside the configured result size
  `MM_ASSERT_IMP(a_ok_row, out_valid_o && (status_o == ST_OK), (CFG_W'(out_row_o) < cfg_q.a_rows) && (CFG_W'(out_col_o) < cfg_q.b_cols), "product index outside result size")

  // the last product element is the bottom-right corner
  `MM_ASSERT_IMP(a_ok_corner, out_valid_o && (status_o == ST_OK) && last_o, ((CFG_W'(out_row_o) + CFG_W'(1)) == cfg_q.a_rows) && ((CFG_W'(out_col_o) + CFG_W'(1)) == cfg_q.b_cols), "last flag away from final element")

  // a stalled result stays put until it is taken
  `MM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(product_value_o), "result changed while stalled")

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the matrix multiply block: loads of A and B, size
// registers over apb, product runs checked element by element against a
// behavioural predictor, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mm_pkg::*;

  localparam int unsigned MAX_DIM        = MAX_DIM_DEF;
  localparam int unsigned STORE_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned RANDOM_ITEMS   = 50;
  // quiet time after draining, so that accepted loads still in flight reach their stores
  localparam int unsigned IDLE_GAP       = 24;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned HOLD_CYCLES    = 400;
  // worst quiet stretch: hold-off + one element + sender gap
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // one input transaction
  typedef struct packed {
    mm_cmd_e              cmd;
    logic [IDX_IN_W-1:0]  row;
    logic [IDX_IN_W-1:0]  col;
    logic [IN_W-1:0]      value;
  } mat_txn_t;

  // one expected element of C (or error report)
  typedef struct packed {
    logic [IDX_IN_W-1:0]  row;
    logic [IDX_IN_W-1:0]  col;
    logic [OUT_W-1:0]     value;
    mm_status_e           status;
    logic                 last;
  } c_elem_t;

  typedef enum logic [1:0] {
    READY_FULL,
    READY_COIN,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_e;

  // clock, reset and dut ports; the dut inputs are all known from time zero
  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       psel            = 1'b0;
  logic                       penable         = 1'b0;
  logic                       pwrite          = 1'b0;
  logic        [PADDR_W-1:0]  paddr           = '0;
  logic        [PDATA_W-1:0]  pwdata          = '0;
  logic        [PDATA_W-1:0]  prdata;
  logic                       pready;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic        [CMD_W-1:0]    cmd_i           = CMD_NONE;
  logic        [IDX_IN_W-1:0] row_index_i     = '0;
  logic        [IDX_IN_W-1:0] col_index_i     = '0;
  logic signed [IN_W-1:0]     element_value_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic        [IDX_IN_W-1:0] out_row_o;
  logic        [IDX_IN_W-1:0] out_col_o;
  logic signed [OUT_W-1:0]    product_value_o;
  logic        [STATUS_W-1:0] status_o;
  logic                       last_o;

  // predictor state: sizes as the block holds them and shadow copies of the stores
  mm_dims_t                   size_cfg;
  logic        [IN_W-1:0]     shadow_a [STORE_DEPTH];
  logic        [IN_W-1:0]     shadow_b [STORE_DEPTH];
  c_elem_t                    expected_elems [$];

  // stimulus side: sizes and which entries have been loaded, as seen when queueing
  mm_dims_t                   gen_dims;
  bit                         a_loaded [STORE_DEPTH];
  bit                         b_loaded [STORE_DEPTH];
  mat_txn_t                   pending_txns [$];
  int unsigned                issued_count  = 0;
  int unsigned                taken_count   = 0;
  int unsigned                stim_count    = 0;
  int unsigned                fail_count    = 0;
  int unsigned                hold_requests = 0;

  matrix_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // size register write: zero reads as one, anything above the maximum saturates
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [PDATA_W-1:0] raw);
    if (raw[CFG_W-1:0] == '0) return CFG_W'(1);
    if (raw[CFG_W-1:0] > MAX_DIM) return CFG_W'(MAX_DIM);
    return raw[CFG_W-1:0];
  endfunction

  function automatic void push_elem(input int unsigned row, input int unsigned col,
                                    input logic [OUT_W-1:0] value, input mm_status_e status,
                                    input logic last);
    c_elem_t e;
    e.row    = IDX_IN_W'(row);
    e.col    = IDX_IN_W'(col);
    e.value  = value;
    e.status = status;
    e.last   = last;
    expected_elems.push_back(e);
  endfunction

  // expected results of one accepted transaction, updating the shadow stores
  function automatic void predict_elems(input mat_txn_t txn);
    int unsigned      nr;
    int unsigned      nc;
    int unsigned      n;
    int unsigned      total;
    logic [OUT_W-1:0] acc;
    case (txn.cmd)
      CMD_WRITE_A, CMD_WRITE_B: begin
        nr = (txn.cmd == CMD_WRITE_A) ? size_cfg.a_rows : size_cfg.b_rows;
        nc = (txn.cmd == CMD_WRITE_A) ? size_cfg.a_cols : size_cfg.b_cols;
        if (txn.row >= nr || txn.col >= nc) begin
          // bad index: echo it, store untouched
          push_elem(txn.row, txn.col, '0, ST_RANGE, 1'b1);
        end else if (txn.cmd == CMD_WRITE_A) begin
          shadow_a[txn.row * MAX_DIM + txn.col] = txn.value;
        end else begin
          shadow_b[txn.row * MAX_DIM + txn.col] = txn.value;
        end
      end
      CMD_COMPUTE: begin
        if (size_cfg.a_cols != size_cfg.b_rows) begin
          push_elem(0, 0, '0, ST_MISMATCH, 1'b1);
        end else begin
          n     = 0;
          total = size_cfg.a_rows * size_cfg.b_cols;
          for (int i = 0; i < size_cfg.a_rows; i++) begin
            for (int j = 0; j < size_cfg.b_cols; j++) begin
              acc = '0;
              // 32-bit wrap on every product and sum
              for (int k = 0; k < size_cfg.a_cols; k++) begin
                acc = acc + shadow_a[i * MAX_DIM + k] * shadow_b[k * MAX_DIM + j];
              end
              n++;
              push_elem(i, j, acc, ST_OK, n == total);
            end
          end
        end
      end
      default: begin
        // unused command, silently dropped
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // sender: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin : sender
    mat_txn_t txn;
    logic     offering;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        txn.cmd   = mm_cmd_e'(cmd_i);
        txn.row   = row_index_i;
        txn.col   = col_index_i;
        txn.value = element_value_i;
        predict_elems(txn);
        taken_count++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 7))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6:    gap_left = $urandom_range(1, 3);
            default:    gap_left = $urandom_range(4, 16);
          endcase
        end
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_txns.size() != 0) begin
          txn = pending_txns.pop_front();
          burst_left--;
          in_valid_i      <= 1'b1;
          cmd_i           <= txn.cmd;
          row_index_i     <= txn.row;
          col_index_i     <= txn.col;
          element_value_i <= txn.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern that changes mode now and then, plus a long hold-off
  // --------------------------------------------------------------------------
  ready_mode_e ready_mode = READY_FULL;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;
  int unsigned ready_tick = 0;

  always @(posedge clk_i or negedge rst_ni) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      ready_tick++;
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        // hold-off: block fills up and must stall its input
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 3));
          mode_left  = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          READY_FULL:   out_ready_i <= 1'b1;
          READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_ready_i <= (ready_tick % 4 == 0);
          default:      out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: each transaction against the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] expected,
                                      input logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(expected), $signed(actual));
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    c_elem_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_elems.size() == 0) begin
        $error("result with nothing expected: row %0d col %0d value %0d status %0d",
               out_row_o, out_col_o, product_value_o, status_o);
        fail_count++;
      end else begin
        e = expected_elems.pop_front();
        check_field("out_row", 32'(e.row), 32'(out_row_o));
        check_field("out_col", 32'(e.col), 32'(out_col_o));
        check_field("product_value", e.value, product_value_o);
        check_field("status", 32'(e.status), 32'(status_o));
        check_field("last", 32'(e.last), 32'(last_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any transaction on either channel
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[matrix_multiply] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // element values: extremes, small signed, or anything
  function automatic logic [IN_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 8) - 32'd4;
      default: return $urandom();
    endcase
  endfunction

  // raw size register value: mostly small, sometimes full, zero or oversize
  function automatic logic [PDATA_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return $urandom_range(9, 15);
      2:       return ($urandom() & 32'hffff_fff0) | $urandom_range(1, 3);
      3:       return MAX_DIM;
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic void queue_txn(input mm_cmd_e cmd, input int unsigned row,
                                    input int unsigned col, input logic [IN_W-1:0] value);
    mat_txn_t txn;
    txn.cmd   = cmd;
    txn.row   = IDX_IN_W'(row);
    txn.col   = IDX_IN_W'(col);
    txn.value = value;
    if (cmd == CMD_WRITE_A && row < gen_dims.a_rows && col < gen_dims.a_cols) begin
      a_loaded[row * MAX_DIM + col] = 1'b1;
    end
    if (cmd == CMD_WRITE_B && row < gen_dims.b_rows && col < gen_dims.b_cols) begin
      b_loaded[row * MAX_DIM + col] = 1'b1;
    end
    if (cmd != CMD_NONE) stim_count++;
    issued_count++;
    pending_txns.push_back(txn);
  endfunction

  // noise: unused command or a load with an index outside the current size (any index if the target is at full size)
  function automatic void queue_noise();
    mm_cmd_e     target;
    int unsigned nr;
    int unsigned nc;
    int unsigned r;
    int unsigned c;
    target = ($urandom_range(0, 1) == 1) ? CMD_WRITE_B : CMD_WRITE_A;
    nr     = (target == CMD_WRITE_A) ? gen_dims.a_rows : gen_dims.b_rows;
    nc     = (target == CMD_WRITE_A) ? gen_dims.a_cols : gen_dims.b_cols;
    r      = $urandom_range(0, MAX_DIM - 1);
    c      = $urandom_range(0, MAX_DIM - 1);
    if ($urandom_range(0, 3) == 0) begin
      queue_txn(CMD_NONE, r, c, $urandom());
    end else begin
      if (nr < MAX_DIM && (nc == MAX_DIM || $urandom_range(0, 1) == 1)) begin
        r = $urandom_range(MAX_DIM - 1, nr);
      end else if (nc < MAX_DIM) begin
        c = $urandom_range(MAX_DIM - 1, nc);
      end
      queue_txn(target, r, c, pick_value());
    end
  endfunction

  // load every entry of A and B in use, with the odd bit of noise in between
  function automatic void queue_matrices();
    for (int i = 0; i < gen_dims.a_rows; i++) begin
      for (int k = 0; k < gen_dims.a_cols; k++) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        queue_txn(CMD_WRITE_A, i, k, pick_value());
      end
    end
    for (int k = 0; k < gen_dims.b_rows; k++) begin
      for (int j = 0; j < gen_dims.b_cols; j++) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        queue_txn(CMD_WRITE_B, k, j, pick_value());
      end
    end
  endfunction

  // product run; any entry it would read that was never loaded is loaded first
  function automatic void queue_compute();
    if (gen_dims.a_cols == gen_dims.b_rows) begin
      for (int i = 0; i < gen_dims.a_rows; i++) begin
        for (int k = 0; k < gen_dims.a_cols; k++) begin
          if (!a_loaded[i * MAX_DIM + k]) queue_txn(CMD_WRITE_A, i, k, pick_value());
        end
      end
      for (int k = 0; k < gen_dims.b_rows; k++) begin
        for (int j = 0; j < gen_dims.b_cols; j++) begin
          if (!b_loaded[k * MAX_DIM + j]) queue_txn(CMD_WRITE_B, k, j, pick_value());
        end
      end
    end
    queue_txn(CMD_COMPUTE, $urandom_range(0, MAX_DIM - 1), $urandom_range(0, MAX_DIM - 1),
              $urandom());
  endfunction

  // a few single-entry reloads and noise between two runs
  function automatic void queue_reloads();
    int unsigned count;
    count = $urandom_range(2, 6);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        queue_noise();
      end else if ($urandom_range(0, 1) == 1) begin
        queue_txn(CMD_WRITE_A, $urandom_range(0, gen_dims.a_rows - 1),
                  $urandom_range(0, gen_dims.a_cols - 1), pick_value());
      end else begin
        queue_txn(CMD_WRITE_B, $urandom_range(0, gen_dims.b_rows - 1),
                  $urandom_range(0, gen_dims.b_cols - 1), pick_value());
      end
    end
  endfunction

  // everything taken, every result back, then room for loads still in flight
  task automatic wait_until_drained();
    while (taken_count != issued_count || expected_elems.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // apb write: setup cycle, access cycle, register taken at the end of access
  task automatic write_size(input mm_reg_e reg_sel, input logic [PDATA_W-1:0] raw);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= raw;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_sel)
      REG_A_ROWS: size_cfg.a_rows = clamp_dim(raw);
      REG_A_COLS: size_cfg.a_cols = clamp_dim(raw);
      REG_B_ROWS: size_cfg.b_rows = clamp_dim(raw);
      default:    size_cfg.b_cols = clamp_dim(raw);
    endcase
    gen_dims = size_cfg;
  endtask

  task automatic resize(input logic [PDATA_W-1:0] a_rows_raw, input logic [PDATA_W-1:0] a_cols_raw,
                        input logic [PDATA_W-1:0] b_rows_raw, input logic [PDATA_W-1:0] b_cols_raw);
    wait_until_drained();
    write_size(REG_A_ROWS, a_rows_raw);
    write_size(REG_A_COLS, a_cols_raw);
    write_size(REG_B_ROWS, b_rows_raw);
    write_size(REG_B_COLS, b_cols_raw);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : sequence_ctrl
    int unsigned          random_base;
    logic [PDATA_W-1:0]   a_cols_raw;
    logic [PDATA_W-1:0]   b_rows_raw;
    size_cfg = {CFG_W'(DIM_RESET), CFG_W'(DIM_RESET), CFG_W'(DIM_RESET), CFG_W'(DIM_RESET)};
    gen_dims = size_cfg;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full size after reset: corner loads with extreme values, unused command ignored
    queue_txn(CMD_WRITE_A, 0, 0, 32'h8000_0000);
    queue_txn(CMD_WRITE_A, MAX_DIM - 1, MAX_DIM - 1, 32'h7fff_ffff);
    queue_txn(CMD_WRITE_B, 0, MAX_DIM - 1, 32'hffff_ffff);
    queue_txn(CMD_WRITE_B, MAX_DIM - 1, 0, 32'h0000_0000);
    queue_txn(CMD_NONE, MAX_DIM - 1, MAX_DIM - 1, 32'hffff_ffff);

    // 1x2 times 2x1, zero written to the row and column counts reads as one
    resize(0, 2, 2, 0);
    queue_txn(CMD_WRITE_A, 0, 0, 32'h7fff_ffff);
    queue_txn(CMD_WRITE_A, 0, 1, 32'h7fff_ffff);
    queue_txn(CMD_WRITE_B, 0, 0, 32'h7fff_ffff);
    queue_txn(CMD_WRITE_B, 1, 0, 32'h8000_0000);
    // loads outside the size: row and column on each matrix, both on A
    queue_txn(CMD_WRITE_A, 1, 0, 32'h1234_5678);
    queue_txn(CMD_WRITE_A, 0, 2, 32'h1234_5678);
    queue_txn(CMD_WRITE_B, 2, 0, 32'h1234_5678);
    queue_txn(CMD_WRITE_B, 0, 1, 32'h1234_5678);
    queue_txn(CMD_WRITE_A, MAX_DIM - 1, MAX_DIM - 1, 32'h1234_5678);
    queue_compute();

    // inner sizes disagree: single error result
    resize(0, 2, 3, 0);
    queue_txn(CMD_WRITE_B, 2, 0, 32'hffff_fffe);
    queue_compute();

    // 8x1 times 1x8, the largest result count, with the receiver holding off
    resize(15, 1, 1, MAX_DIM);
    hold_requests <= hold_requests + 1;
    queue_matrices();
    queue_compute();
    queue_matrices();
    queue_compute();

    // 1x8 times 8x1, the longest sum
    resize(1, 12, MAX_DIM, 1);
    queue_matrices();
    queue_compute();

    // random phases: new sizes, full loads, one or two runs each
    random_base = stim_count;
    while (stim_count - random_base < RANDOM_ITEMS) begin
      a_cols_raw = pick_dim();
      b_rows_raw = ($urandom_range(0, 5) == 0) ? pick_dim() : a_cols_raw;
      resize(pick_dim(), a_cols_raw, b_rows_raw, pick_dim());
      queue_matrices();
      queue_compute();
      if ($urandom_range(0, 1) == 1) begin
        queue_reloads();
        queue_compute();
      end
    end

    wait_until_drained();
    if (fail_count == 0) begin
      $display("[matrix_multiply] OK");
    end else begin
      $display("[matrix_multiply] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
